>>> hdl/timer_slot_table_macros.svh
// assertion macros used by the timer slot table checker
// no dependencies; taken in by `include where assertions are written
`ifndef TIMER_SLOT_TABLE_MACROS_SVH
`define TIMER_SLOT_TABLE_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define TST_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define TST_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tst_pkg.sv
// shared types, codes and field layout of the timer slot table
// no dependencies; imported by every module of the block but tst_ram
`timescale 1ns / 1ps

package tst_pkg;

    // table size and derived widths
    localparam int SLOT_COUNT = 64;
    localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

    // field widths
    localparam int REQ_W    = 2;
    localparam int SLOT_W   = 6;
    localparam int TAG_W    = 16;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 2;

    // input stream layout, first field lowest
    localparam int IN_SLOT_LSB  = 0;
    localparam int IN_TAG_LSB   = IN_SLOT_LSB + SLOT_W;
    localparam int IN_DELAY_LSB = IN_TAG_LSB + TAG_W;
    localparam int IN_NOW_LSB   = IN_DELAY_LSB + TIME_W;
    localparam int IN_USED_W    = IN_NOW_LSB + TIME_W;
    localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

    // output stream layout
    localparam int OUT_SLOT_LSB = 0;
    localparam int OUT_REM_LSB  = OUT_SLOT_LSB + SLOT_W;
    localparam int OUT_USED_W   = OUT_REM_LSB + TIME_W;
    localparam int OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_USED_W;
    localparam int OUT_USER_W   = STATUS_W + 1;

    // request codes
    localparam logic [REQ_W-1:0] REQ_REGISTER = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RESET    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK     = 2'd2;
    localparam logic [REQ_W-1:0] REQ_REARM    = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // one classified request as it waits in the queue
    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [SLOT_W-1:0] slot_id;
        logic [TAG_W-1:0]  owner_tag;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] now;
        logic              id_bad;
    } tst_req_t;

endpackage

>>> hdl/tst_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies; used for the deadline and owner tag stores
`timescale 1ns / 1ps

module tst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [WIDTH-1:0]           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/tst_front.sv
// front end: takes requests from the input stream, classifies them, queues them
// depends on tst_pkg
`timescale 1ns / 1ps

module tst_front import tst_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,   // slot_id, owner_tag, delay, now, zero pad
    input  logic [REQ_W-1:0]     s_tuser,   // req_type
    output logic                 q_valid,
    output tst_req_t             q_data,
    input  logic                 q_pop
);

    tst_req_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;
    logic                push;
    logic                pop;
    tst_req_t            in_req;

    // unpack and classify the incoming request
    always_comb
    begin
        in_req.req_type  = s_tuser;
        in_req.slot_id   = s_tdata[IN_SLOT_LSB +: SLOT_W];
        in_req.owner_tag = s_tdata[IN_TAG_LSB +: TAG_W];
        in_req.delay     = s_tdata[IN_DELAY_LSB +: TIME_W];
        in_req.now       = s_tdata[IN_NOW_LSB +: TIME_W];
        in_req.id_bad    = ({1'b0, in_req.slot_id} >= (SLOT_W + 1)'(SLOT_COUNT));
    end

    // queue handshake
    assign s_tready = (count_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_data   = entry_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

>>> hdl/tst_back.sv
// back end: carries out queued requests on the slot bitmap and slot stores
// depends on tst_pkg and tst_ram
`timescale 1ns / 1ps

module tst_back import tst_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  tst_req_t              q_data,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // result_slot, remaining, zero pad
    output logic [OUT_USER_W-1:0] m_tuser,  // status, fired
    output logic                  m_tlast
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ALLOC  = 3'd1;
    localparam logic [2:0] S_LOOKUP = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_CHECK  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    tst_req_t              op_reg;
    tst_req_t              op_next;
    logic [CNT_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      idx_next;
    logic [SLOT_COUNT-1:0] active_reg;
    logic [SLOT_COUNT-1:0] active_next;
    logic                  pend_valid_reg;
    logic                  pend_valid_next;
    logic [SLOT_AW-1:0]    pend_slot_reg;
    logic [SLOT_AW-1:0]    pend_slot_next;

    logic [STATUS_W-1:0]   res_status_reg;
    logic [STATUS_W-1:0]   res_status_next;
    logic [SLOT_W-1:0]     res_slot_reg;
    logic [SLOT_W-1:0]     res_slot_next;
    logic [TIME_W-1:0]     res_remaining_reg;
    logic [TIME_W-1:0]     res_remaining_next;
    logic                  res_fired_reg;
    logic                  res_fired_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [STATUS_W-1:0]   out_status_next;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic [SLOT_W-1:0]     out_slot_next;
    logic [TIME_W-1:0]     out_remaining_reg;
    logic [TIME_W-1:0]     out_remaining_next;
    logic                  out_fired_reg;
    logic                  out_fired_next;
    logic                  out_last_reg;
    logic                  out_last_next;

    logic                  out_free;
    logic                  out_load;
    logic [STATUS_W-1:0]   ld_status;
    logic [SLOT_W-1:0]     ld_slot;
    logic [TIME_W-1:0]     ld_remaining;
    logic                  ld_fired;
    logic                  ld_last;

    logic [SLOT_AW-1:0]    idx_slot;
    logic [SLOT_AW-1:0]    op_slot;
    logic [SLOT_AW-1:0]    q_slot;
    logic                  idx_end;

    logic                  dl_we;
    logic                  tag_we;
    logic [SLOT_AW-1:0]    mem_waddr;
    logic [TIME_W-1:0]     dl_wdata;
    logic                  mem_re;
    logic [SLOT_AW-1:0]    mem_raddr;
    logic [TIME_W-1:0]     dl_rdata;
    logic [TAG_W-1:0]      tag_rdata;

    logic [TIME_W-1:0]     sum_now_delay;
    logic [TIME_W-1:0]     sum_rearm;
    logic [TIME_W-1:0]     time_left;
    logic                  dl_after_now;

    // deadline and owner tag stores
    tst_ram #(
        .WIDTH (TIME_W),
        .DEPTH (SLOT_COUNT)
    ) u_deadline_ram (
        .clk     (clk),
        .wr_en   (dl_we),
        .wr_addr (mem_waddr),
        .wr_data (dl_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (dl_rdata)
    );

    tst_ram #(
        .WIDTH (TAG_W),
        .DEPTH (SLOT_COUNT)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (tag_we),
        .wr_addr (mem_waddr),
        .wr_data (op_reg.owner_tag),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (tag_rdata)
    );

    // slot indices and time arithmetic
    assign idx_slot      = idx_reg[SLOT_AW-1:0];
    assign op_slot       = op_reg.slot_id[SLOT_AW-1:0];
    assign q_slot        = q_data.slot_id[SLOT_AW-1:0];
    assign idx_end       = (idx_reg == CNT_W'(SLOT_COUNT));
    assign sum_now_delay = op_reg.now + op_reg.delay;
    assign sum_rearm     = dl_rdata + op_reg.delay;
    assign time_left     = dl_rdata - op_reg.now;
    assign dl_after_now  = (dl_rdata > op_reg.now);
    assign out_free      = !out_valid_reg || m_tready;

    // request sequencer
    always_comb
    begin
        state_next         = state_reg;
        op_next            = op_reg;
        idx_next           = idx_reg;
        active_next        = active_reg;
        pend_valid_next    = pend_valid_reg;
        pend_slot_next     = pend_slot_reg;
        res_status_next    = res_status_reg;
        res_slot_next      = res_slot_reg;
        res_remaining_next = res_remaining_reg;
        res_fired_next     = res_fired_reg;
        q_pop              = 1'b0;
        dl_we              = 1'b0;
        tag_we             = 1'b0;
        mem_waddr          = op_slot;
        dl_wdata           = sum_now_delay;
        mem_re             = 1'b0;
        mem_raddr          = idx_slot;
        out_load           = 1'b0;
        ld_status          = ST_OK;
        ld_slot            = SLOT_W'(pend_slot_reg);
        ld_remaining       = '0;
        ld_fired           = 1'b1;
        ld_last            = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop              = 1'b1;
                    op_next            = q_data;
                    idx_next           = '0;
                    pend_valid_next    = 1'b0;
                    res_slot_next      = q_data.slot_id;
                    res_remaining_next = '0;
                    res_fired_next     = 1'b0;
                    case (q_data.req_type)
                        REQ_REGISTER:
                        begin
                            state_next = S_ALLOC;
                        end
                        REQ_TICK:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            if (q_data.id_bad || !active_reg[q_slot])
                            begin
                                res_status_next = ST_INVALID;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = q_slot;
                                state_next = S_LOOKUP;
                            end
                        end
                    endcase
                end
            end

            // walk the bitmap for the lowest free slot
            S_ALLOC:
            begin
                if (idx_end)
                begin
                    res_status_next = ST_FULL;
                    res_slot_next   = '0;
                    state_next      = S_DONE;
                end
                else if (!active_reg[idx_slot])
                begin
                    active_next[idx_slot] = 1'b1;
                    dl_we                 = 1'b1;
                    tag_we                = 1'b1;
                    mem_waddr             = idx_slot;
                    res_status_next       = ST_OK;
                    res_slot_next         = SLOT_W'(idx_slot);
                    state_next            = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            // stored entry is on the read port: reset or rearm
            S_LOOKUP:
            begin
                state_next      = S_DONE;
                res_status_next = ST_OK;
                if (op_reg.req_type == REQ_RESET)
                begin
                    if (tag_rdata != op_reg.owner_tag)
                    begin
                        res_status_next = ST_INVALID;
                    end
                    else
                    begin
                        res_remaining_next = dl_after_now ? time_left : '0;
                        dl_we              = 1'b1;
                        if (op_reg.delay == '0)
                        begin
                            active_next[op_slot] = 1'b0;
                        end
                    end
                end
                else
                begin
                    if (op_reg.delay == '0)
                    begin
                        active_next[op_slot] = 1'b0;
                    end
                    else
                    begin
                        dl_we    = 1'b1;
                        dl_wdata = sum_rearm;
                    end
                end
            end

            // tick: skip idle slots, fetch deadlines of active ones
            S_SCAN:
            begin
                if (idx_end)
                begin
                    res_status_next    = ST_OK;
                    res_slot_next      = pend_valid_reg ? SLOT_W'(pend_slot_reg) : '0;
                    res_remaining_next = '0;
                    res_fired_next     = pend_valid_reg;
                    state_next         = S_DONE;
                end
                else if (active_reg[idx_slot])
                begin
                    mem_re     = 1'b1;
                    state_next = S_CHECK;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            // expired slot: send the one held back, if any, and hold this one
            S_CHECK:
            begin
                if (!dl_after_now)
                begin
                    if (!pend_valid_reg)
                    begin
                        pend_valid_next = 1'b1;
                        pend_slot_next  = idx_slot;
                        idx_next        = idx_reg + CNT_W'(1);
                        state_next      = S_SCAN;
                    end
                    else if (out_free)
                    begin
                        out_load       = 1'b1;
                        pend_slot_next = idx_slot;
                        idx_next       = idx_reg + CNT_W'(1);
                        state_next     = S_SCAN;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_SCAN;
                end
            end

            // final result of the request
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    ld_status    = res_status_reg;
                    ld_slot      = res_slot_reg;
                    ld_remaining = res_remaining_reg;
                    ld_fired     = res_fired_reg;
                    ld_last      = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next     = out_valid_reg;
        out_status_next    = out_status_reg;
        out_slot_next      = out_slot_reg;
        out_remaining_next = out_remaining_reg;
        out_fired_next     = out_fired_reg;
        out_last_next      = out_last_reg;
        if (out_load)
        begin
            out_valid_next     = 1'b1;
            out_status_next    = ld_status;
            out_slot_next      = ld_slot;
            out_remaining_next = ld_remaining;
            out_fired_next     = ld_fired;
            out_last_next      = ld_last;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            active_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            active_reg     <= active_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg            <= op_next;
        pend_slot_reg     <= pend_slot_next;
        res_status_reg    <= res_status_next;
        res_slot_reg      <= res_slot_next;
        res_remaining_reg <= res_remaining_next;
        res_fired_reg     <= res_fired_next;
        out_status_reg    <= out_status_next;
        out_slot_reg      <= out_slot_next;
        out_remaining_reg <= out_remaining_next;
        out_fired_reg     <= out_fired_next;
        out_last_reg      <= out_last_next;
    end

    // result stream packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_remaining_reg, out_slot_reg};
    assign m_tuser  = {out_fired_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

endmodule

>>> hdl/timer_slot_table.sv
// Timer slot table, 64 one-shot or periodic slots with owner tags. Requests
// enter a two-entry queue, so up to two are taken while an earlier one is
// still being carried out; results leave through an output register. Each
// request is worked on alone: register walks the active bitmap one slot a
// cycle up to the lowest free slot, or to the end when the table is full;
// reset and rearm read the deadline and tag stores once, then write; a tick
// walks every slot in ascending order and fetches the deadline of each active
// slot through the single read port of the deadline store. A tick returns one
// result per expired slot in ascending order, the last with tlast set, or a
// single result with fired clear when nothing has expired. Stalls on the
// result side hold up the request being worked on. Times compare unsigned,
// without wrap.
// depends on tst_pkg, tst_front, tst_back
`timescale 1ns / 1ps

module timer_slot_table import tst_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // slot_id, owner_tag, delay, now, zero pad
    input  logic [REQ_W-1:0]      s_tuser,   // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // result_slot, remaining, zero pad
    output logic [OUT_USER_W-1:0] m_tuser,   // status, fired
    output logic                  m_tlast
);

    logic     q_valid;
    tst_req_t q_data;
    logic     q_pop;

    // request intake and queue
    tst_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    // request execution and results
    tst_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> hdl/tst_checker.sv
// port-level checks on the result stream of the timer slot table
// depends on tst_pkg and timer_slot_table_macros.svh; bound to timer_slot_table
`timescale 1ns / 1ps
`include "timer_slot_table_macros.svh"

module tst_checker import tst_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [OUT_USER_W-1:0] m_tuser,
    input logic                  m_tlast
);

    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   result_slot;
    logic [TIME_W-1:0]   remaining;
    logic                fired;

    assign status      = m_tuser[STATUS_W-1:0];
    assign fired       = m_tuser[STATUS_W];
    assign result_slot = m_tdata[OUT_SLOT_LSB +: SLOT_W];
    assign remaining   = m_tdata[OUT_REM_LSB +: TIME_W];

    // a fired slot is always a good result with no time left
    `TST_ASSERT_IMP(a_fired_ok, clk, rst_n, m_tvalid && fired,
        status == ST_OK && remaining == '0, "fired result with bad status or time")

    // only tick results for expired slots may come before the last one
    `TST_ASSERT_IMP(a_mid_fired, clk, rst_n, m_tvalid && !m_tlast,
        fired && status == ST_OK, "non-final result that is not a fired slot")

    // full table reports slot zero in a single result
    `TST_ASSERT_IMP(a_full_form, clk, rst_n, m_tvalid && status == ST_FULL,
        result_slot == '0 && m_tlast && !fired, "malformed table full result")

    // time left only comes with a good reset result
    `TST_ASSERT_IMP(a_left_ok, clk, rst_n, m_tvalid && remaining != '0,
        status == ST_OK && !fired && m_tlast, "time left on a wrong result")

    // a stalled result holds
    `TST_ASSERT_NXT(a_stall_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "result changed while stalled")

endmodule

bind timer_slot_table tst_checker u_tst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
